// ----- rtl/dcmf_pkg.sv -----
`timescale 1ns / 1ps

package dcmf_pkg;

   // Line store geometry: four rows of up to 1024 channel minima.
   localparam int MaxWidth  = 1024;
   localparam int ColBits   = 10;
   localparam int LineBits  = 2;
   localparam int AddrBits  = LineBits + ColBits;
   localparam int DimBits   = 11;
   localparam int RowBits   = 11;
   localparam int LeadBits  = 11;
   localparam int PixBits   = 8;

   localparam logic [PixBits-1:0] Border      = 8'hFF;
   localparam logic [DimBits-1:0] WidthReset  = 11'd640;
   localparam logic [DimBits-1:0] HeightReset = 11'd480;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Per-transaction control that travels from the position logic to the window stage.
   typedef struct packed {
      logic               produce;
      logic               last;
      logic [PixBits-1:0] bottom;
      logic               top_ok;
      logic               mid_ok;
      logic               bot_ok;
      logic               left_ok;
      logic               center_ok;
      logic               right_ok;
   } win_ctl_type;

   function automatic logic [PixBits-1:0] min2(input logic [PixBits-1:0] a,
                                               input logic [PixBits-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PixBits-1:0] min3(input logic [PixBits-1:0] a,
                                               input logic [PixBits-1:0] b,
                                               input logic [PixBits-1:0] c);
      return min2(min2(a, b), c);
   endfunction

   function automatic logic [PixBits-1:0] keep(input logic [PixBits-1:0] v,
                                               input logic ok);
      return ok ? v : Border;
   endfunction

endpackage

// ----- rtl/dcmf_line_store.sv -----
`timescale 1ns / 1ps

module dcmf_line_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [dcmf_pkg::AddrBits-1:0]    wr_addr,
   input  logic [dcmf_pkg::PixBits-1:0]     wr_data,
   input  logic                             rd_en,
   input  logic [dcmf_pkg::AddrBits-1:0]    rd_addr0,
   input  logic [dcmf_pkg::AddrBits-1:0]    rd_addr1,
   output logic [dcmf_pkg::PixBits-1:0]     rd_data0,
   output logic [dcmf_pkg::PixBits-1:0]     rd_data1
);
   import dcmf_pkg::*;

   localparam int Depth = 1 << AddrBits;

   logic [PixBits-1:0] mem_ff [Depth];
   logic [PixBits-1:0] rd_data0_ff;
   logic [PixBits-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds while the window stage is stalled.
      if (rd_en) begin
         rd_data0_ff <= mem_ff[rd_addr0];
         rd_data1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ----- rtl/dcmf_pos_ctrl.sv -----
`timescale 1ns / 1ps

module dcmf_pos_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [0:0]                       csr_index,
   input  logic [dcmf_pkg::DimBits-1:0]     csr_data,
   output logic                             csr_ready,
   input  logic                             accept,
   input  logic [dcmf_pkg::PixBits-1:0]     blue,
   input  logic [dcmf_pkg::PixBits-1:0]     green,
   input  logic [dcmf_pkg::PixBits-1:0]     red,
   input  logic                             flush,
   output logic                             wr_en,
   output logic [dcmf_pkg::AddrBits-1:0]    wr_addr,
   output logic [dcmf_pkg::PixBits-1:0]     wr_data,
   output logic                             rd_en,
   output logic [dcmf_pkg::AddrBits-1:0]    rd_addr0,
   output logic [dcmf_pkg::AddrBits-1:0]    rd_addr1,
   output dcmf_pkg::win_ctl_type            ctl
);
   import dcmf_pkg::*;

   logic [DimBits-1:0]  width_ff, width_in;
   logic [DimBits-1:0]  height_ff, height_in;
   logic [ColBits-1:0]  in_col_ff, in_col_in;
   logic [RowBits-1:0]  in_row_ff, in_row_in;
   logic [ColBits-1:0]  out_col_ff, out_col_in;
   logic [RowBits-1:0]  out_row_ff, out_row_in;
   logic [LeadBits-1:0] lead_ff, lead_in;

   logic [DimBits-1:0]  w_eff;
   logic [DimBits-1:0]  h_eff;
   logic [LeadBits-1:0] lead_eff;
   logic [DimBits-1:0]  in_col_inc;
   logic [DimBits-1:0]  out_col_inc;
   logic [RowBits:0]    out_row_inc;
   logic                in_frame;
   logic                produce;
   logic                last;
   logic [PixBits-1:0]  pix_min;
   logic [LineBits-1:0] line;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = DimBits'(1);
      end else if (width_ff > DimBits'(MaxWidth)) begin
         w_eff = DimBits'(MaxWidth);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? DimBits'(1) : height_ff;
   end

   // One row plus one pixel of input goes in before the first result.
   assign lead_eff    = LeadBits'(w_eff) + LeadBits'(1);
   assign produce     = lead_ff >= lead_eff;
   assign in_frame    = (in_row_ff < RowBits'(h_eff)) && ({1'b0, in_col_ff} < w_eff);
   assign in_col_inc  = {1'b0, in_col_ff} + DimBits'(1);
   assign out_col_inc = {1'b0, out_col_ff} + DimBits'(1);
   assign out_row_inc = {1'b0, out_row_ff} + (RowBits + 1)'(1);
   assign last        = (out_row_inc >= {1'b0, h_eff}) && (out_col_inc >= w_eff);
   assign pix_min     = min3(blue, green, red);
   assign line        = in_row_ff[LineBits-1:0];

   // The column entering the window sits at the input position: the two rows
   // above come from the store, the current row from this transaction.
   assign wr_en    = accept && in_frame;
   assign wr_addr  = {line, in_col_ff};
   assign wr_data  = flush ? Border : pix_min;
   assign rd_en    = accept;
   assign rd_addr0 = {line - LineBits'(2), in_col_ff};
   assign rd_addr1 = {line - LineBits'(1), in_col_ff};

   always_comb begin
      ctl.produce   = produce;
      ctl.last      = last;
      ctl.bottom    = in_frame ? wr_data : Border;
      ctl.top_ok    = (out_row_ff != '0) && (out_row_ff <= RowBits'(h_eff));
      ctl.mid_ok    = out_row_ff < RowBits'(h_eff);
      ctl.bot_ok    = out_row_inc < {1'b0, h_eff};
      ctl.left_ok   = (out_col_ff != '0) && ({1'b0, out_col_ff} <= w_eff);
      ctl.center_ok = {1'b0, out_col_ff} < w_eff;
      ctl.right_ok  = out_col_inc < w_eff;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lead_in    = lead_ff;
      if (accept) begin
         if (in_col_inc >= w_eff) begin
            in_col_in = '0;
            in_row_in = (in_row_ff == '1) ? in_row_ff : in_row_ff + RowBits'(1);
         end else begin
            in_col_in = in_col_inc[ColBits-1:0];
         end
         if (!produce) begin
            lead_in = lead_ff + LeadBits'(1);
         end else if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lead_in    = '0;
         end else if (out_col_inc >= w_eff) begin
            out_col_in = '0;
            out_row_in = out_row_inc[RowBits-1:0];
         end else begin
            out_col_in = out_col_inc[ColBits-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WidthReset;
         height_ff  <= HeightReset;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lead_ff    <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lead_ff    <= lead_in;
      end
   end

endmodule

// ----- rtl/dcmf_window.sv -----
`timescale 1ns / 1ps

module dcmf_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  dcmf_pkg::win_ctl_type            ctl,
   input  logic [dcmf_pkg::PixBits-1:0]     rd_data0,
   input  logic [dcmf_pkg::PixBits-1:0]     rd_data1,
   output logic                             take_ok,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dcmf_pkg::PixBits-1:0]     rsp_dark,
   output logic                             rsp_last
);
   import dcmf_pkg::*;

   localparam int Rows = 3;

   win_ctl_type        ctl_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic [PixBits-1:0] left_ff [Rows];
   logic [PixBits-1:0] mid_ff  [Rows];
   logic [PixBits-1:0] col_in  [Rows];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PixBits-1:0] rsp_dark_ff;
   logic               rsp_last_ff;
   logic               rsp_free;
   logic               s1_go;
   logic [PixBits-1:0] min_left;
   logic [PixBits-1:0] min_mid;
   logic [PixBits-1:0] min_right;
   logic [PixBits-1:0] dark;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign s1_go    = s1_valid_ff && (!ctl_ff.produce || rsp_free);
   assign take_ok  = !s1_valid_ff || s1_go;

   assign col_in[0] = rd_data0;
   assign col_in[1] = rd_data1;
   assign col_in[2] = ctl_ff.bottom;

   // Masks are applied at use so that positions outside the image read as border.
   assign min_left  = min3(keep(left_ff[0], ctl_ff.top_ok && ctl_ff.left_ok),
                           keep(left_ff[1], ctl_ff.mid_ok && ctl_ff.left_ok),
                           keep(left_ff[2], ctl_ff.bot_ok && ctl_ff.left_ok));
   assign min_mid   = min3(keep(mid_ff[0], ctl_ff.top_ok && ctl_ff.center_ok),
                           keep(mid_ff[1], ctl_ff.mid_ok && ctl_ff.center_ok),
                           keep(mid_ff[2], ctl_ff.bot_ok && ctl_ff.center_ok));
   assign min_right = min3(keep(col_in[0], ctl_ff.top_ok && ctl_ff.right_ok),
                           keep(col_in[1], ctl_ff.mid_ok && ctl_ff.right_ok),
                           keep(col_in[2], ctl_ff.bot_ok && ctl_ff.right_ok));
   assign dark      = min3(min_left, min_mid, min_right);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && ctl_ff.produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < Rows; i++) begin
            left_ff[i] <= Border;
            mid_ff[i]  <= Border;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            for (int i = 0; i < Rows; i++) begin
               left_ff[i] <= mid_ff[i];
               mid_ff[i]  <= col_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff <= ctl;
      end
      if (s1_go && ctl_ff.produce) begin
         rsp_dark_ff <= dark;
         rsp_last_ff <= ctl_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dark  = rsp_dark_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ----- rtl/dark_channel_min_filter_top.sv -----
`timescale 1ns / 1ps

// Dark-channel minimum filter. Takes one pixel per clock in raster order, reduces it to
// the minimum of its three channels and returns the minimum over the 3x3 neighborhood,
// with positions outside the image counting as 255. A new transaction is accepted every
// cycle while the result side does not back-pressure; it is held in the line store read
// register, and the window compare works from that register into the output register.
// Results lag the input by one row plus one pixel: after each frame of W x H pixels the
// source sends W+1 flush transactions (tuser high) to drain it. The only stall comes from
// back-pressure on the result side. Four rows of 1024 entries live in one memory with one
// write and two reads per cycle; it needs no clearing after reset. Write image_width and
// image_height between frames.
module dark_channel_min_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue [7:0], green [15:8], red [23:16]
   input  logic [0:0]  req_tuser,   // flush [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // dark_value [7:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_data
);
   import dcmf_pkg::*;

   logic                accept;
   logic                take_ok;
   logic                wr_en;
   logic [AddrBits-1:0] wr_addr;
   logic [PixBits-1:0]  wr_data;
   logic                rd_en;
   logic [AddrBits-1:0] rd_addr0;
   logic [AddrBits-1:0] rd_addr1;
   logic [PixBits-1:0]  rd_data0;
   logic [PixBits-1:0]  rd_data1;
   win_ctl_type         ctl;

   assign req_tready = take_ok;
   assign accept     = req_tvalid && take_ok;

   dcmf_pos_ctrl u_pos_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .accept    (accept),
      .blue      (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .red       (req_tdata[23:16]),
      .flush     (req_tuser[0]),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1),
      .ctl       (ctl)
   );

   dcmf_line_store u_line_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   dcmf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ctl       (ctl),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1),
      .take_ok   (take_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_dark  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // The input side only stalls behind a result that the sink has not taken.
   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output back-pressure");

   // A store write never lands on a row that the same transaction reads.
   a_no_write_read_overlap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != rd_addr0) && (wr_addr != rd_addr1))
      else $error("line store write overlaps a read of the same transaction");

   // Store accesses happen only with an accepted transaction.
   a_access_with_accept: assert property (@(posedge clock) disable iff (reset)
      (wr_en || rd_en) |-> accept)
      else $error("line store accessed without an accepted transaction");
`endif

endmodule

// ----- dv/tb_dark_channel_min_filter_top.sv -----
`timescale 1ns / 1ps

module tb_dark_channel_min_filter_top;
   import dcmf_pkg::*;

   localparam int StallPct   = 36;
   localparam int QuietLimit = 4000;
   localparam int RandomGoal = 930;

   typedef struct packed {
      logic [PixBits-1:0] dark_value;
      logic               frame_end;
   } dark_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [23:0]        req_tdata = '0;
   logic [0:0]         req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tlast;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_index_type      csr_index = CSR_IMAGE_WIDTH;
   logic [10:0]        csr_data = '0;

   // Shadow of the block: registers, line store and scan positions.
   logic [DimBits-1:0] width_reg  = WidthReset;
   logic [DimBits-1:0] height_reg = HeightReset;
   bit   [7:0]         minima_store [0:4*MaxWidth-1];
   int unsigned        in_col = 0, in_row = 0, out_col = 0, out_row = 0, lead_seen = 0;

   dark_result_type    dark_results_due [$];
   int                 error_count = 0;
   int                 quiet_cycles = 0;
   int unsigned        pixels_sent = 0;
   bit                 steady = 1'b0;

   dark_channel_min_filter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= StallPct);
   end

   // Advances the shadow by one accepted pixel and queues the dark value it releases.
   function automatic void compute_dark_channel(input logic [7:0] blue, input logic [7:0] green,
                                                input logic [7:0] red, input logic flush);
      int unsigned     w, h, best;
      int              y, x;
      logic [7:0]      v;
      dark_result_type res;
      w = (width_reg < 1) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : int'(width_reg));
      h = (height_reg < 1) ? 1 : int'(height_reg);
      if (in_row < h && in_col < w) begin
         v = blue;
         if (green < v) v = green;
         if (red < v) v = red;
         if (flush) v = Border;
         minima_store[(in_row % 4) * MaxWidth + in_col] = v;
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         if (in_row < 24'hFFFFFF) in_row++;
      end
      if (lead_seen < w + 1) begin
         lead_seen++;
         return;
      end
      best = Border;
      for (int dy = -1; dy <= 1; dy++) begin
         y = int'(out_row) + dy;
         if (y < 0 || y >= int'(h)) continue;
         for (int dx = -1; dx <= 1; dx++) begin
            x = int'(out_col) + dx;
            if (x < 0 || x >= int'(w)) continue;
            if (minima_store[(y % 4) * MaxWidth + x] < best)
               best = minima_store[(y % 4) * MaxWidth + x];
         end
      end
      res.dark_value = best[7:0];
      res.frame_end  = (out_row + 1 >= h) && (out_col + 1 >= w);
      dark_results_due = {dark_results_due, res};
      if (res.frame_end) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         lead_seen = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   // Predicts on every input transaction first, then checks any result transaction.
   always @(posedge clock) begin
      dark_result_type due;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_data;
            else height_reg = csr_data;
         end
         if (req_tvalid && req_tready)
            compute_dark_channel(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16], req_tuser[0]);
         if (rsp_tvalid && rsp_tready) begin
            if (dark_results_due.size() == 0) begin
               $error("unexpected result: dark_value %0d frame_end %0d", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               due = dark_results_due.pop_front();
               if (rsp_tdata !== due.dark_value) begin
                  $error("dark_value expected %0d actual %0d", due.dark_value, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== due.frame_end) begin
                  $error("frame_end expected %0d actual %0d", due.frame_end, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called and returning at a falling edge; tvalid stays high so the next call can reuse it.
   task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red, input logic flush);
      bit took;
      while (!steady && $urandom_range(99) < StallPct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {red, green, blue};
      req_tuser  <= flush;
      do begin
         @(posedge clock);
         took = req_tready;
         @(negedge clock);
      end while (!took);
      pixels_sent++;
   endtask

   task automatic write_csr(input csr_index_type index, input logic [10:0] value);
      bit took;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do begin
         @(posedge clock);
         took = csr_ready;
         @(negedge clock);
      end while (!took);
   endtask

   // Registers change only once the previous frame has fully drained.
   task automatic set_frame_size(input logic [10:0] width_value, input logic [10:0] height_value);
      req_tvalid <= 1'b0;
      while (dark_results_due.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      write_csr(CSR_IMAGE_WIDTH, width_value);
      write_csr(CSR_IMAGE_HEIGHT, height_value);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // One frame of w x h pixels followed by the w+1 items that drain it. Some drain items
   // carry real pixels, which the block must treat as padding.
   task automatic send_frame(input int unsigned w, input int unsigned h,
                             input int flush_pct, input int stray_pct);
      for (int unsigned i = 0; i < w * h; i++)
         send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), $urandom_range(99) < flush_pct);
      for (int unsigned i = 0; i <= w; i++)
         send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), !($urandom_range(99) < stray_pct));
   endtask

   task automatic test_small_frames();
      set_frame_size(11'd1, 11'd1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      // Zero width and height both behave as one.
      set_frame_size(11'd0, 11'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd9, 8'd9, 8'd9, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      set_frame_size(11'd3, 11'd2);
      send_pixel(8'd90, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd40, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd17, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd128, 8'd64, 8'd200, 1'b0);
      send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd5, 8'd5, 8'd5, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
   endtask

   task automatic test_size_limits();
      // A zero width acts as one; the tall column wraps the line store rows many times.
      set_frame_size(11'd0, 11'd400);
      send_frame(1, 400, 10, 30);
   endtask

   task automatic test_random_frames();
      int unsigned start_count, w, h;
      logic [10:0] width_value, height_value;
      start_count = pixels_sent;
      while (pixels_sent - start_count < RandomGoal) begin
         w = ($urandom_range(99) < 80) ? $urandom_range(1, 10) : $urandom_range(11, 32);
         h = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
         width_value  = (w == 1 && $urandom_range(1)) ? 11'd0 : w[10:0];
         height_value = (h == 1 && $urandom_range(1)) ? 11'd0 : h[10:0];
         steady = (pixels_sent - start_count > 300) && (pixels_sent - start_count < 600);
         set_frame_size(width_value, height_value);
         send_frame(w, h, 10, 20);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_small_frames();
      test_size_limits();
      test_random_frames();
      req_tvalid <= 1'b0;
      while (dark_results_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
